>>> src/cdeq_pkg.sv
package cdeq_pkg;

    localparam int DEPTH_DEF  = 1024;
    localparam int DATA_W_DEF = 32;

    localparam int OPCODE_W = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_FRONT      = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_BACK       = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_INDEX      = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_SIZE       = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_RESIZE     = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [3:0] {
        K_PUSH_BACK,
        K_POP_BACK,
        K_PUSH_FRONT,
        K_POP_FRONT,
        K_FRONT,
        K_BACK,
        K_INDEX,
        K_SIZE,
        K_CLEAR,
        K_RESIZE,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [POS_W-1:0]    element_count;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    position;
    } cmd_t;

endpackage

>>> src/cdeq_front.sv
module cdeq_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  cdeq_pkg::req_t  req,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output cdeq_pkg::cmd_t  cmd
);
    import cdeq_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_t      cmd_reg;
    cmd_t      cmd_next;
    cmd_kind_t kind;

    always_comb
    begin
        unique case (req.opcode)
            OP_PUSH_BACK:  kind = K_PUSH_BACK;
            OP_POP_BACK:   kind = K_POP_BACK;
            OP_PUSH_FRONT: kind = K_PUSH_FRONT;
            OP_POP_FRONT:  kind = K_POP_FRONT;
            OP_FRONT:      kind = K_FRONT;
            OP_BACK:       kind = K_BACK;
            OP_INDEX:      kind = K_INDEX;
            OP_SIZE:       kind = K_SIZE;
            OP_CLEAR:      kind = K_CLEAR;
            OP_RESIZE:     kind = K_RESIZE;
            default:       kind = K_NOP;
        endcase
    end

    assign req_ready = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg && !cmd_ready;
        cmd_next   = cmd_reg;
        if (req_valid && req_ready)
        begin
            valid_next        = 1'b1;
            cmd_next.kind     = kind;
            cmd_next.value    = req.value;
            cmd_next.position = req.position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

>>> src/cdeq_cmd_fifo.sv
module cdeq_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  cdeq_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cdeq_pkg::cmd_t  pop_cmd
);
    import cdeq_pkg::*;

    localparam int ENTRIES = 2;
    localparam int PTR_W   = $clog2(ENTRIES);
    localparam int USED_W  = $clog2(ENTRIES + 1);

    cmd_t              slots_reg [ENTRIES];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = used_reg != USED_W'(ENTRIES);
    assign pop_valid  = used_reg != '0;
    assign pop_cmd    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        used_next   = used_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ENTRIES - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ENTRIES - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            used_next = used_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> src/cdeq_back.sv
module cdeq_back #(
    parameter int DEPTH  = cdeq_pkg::DEPTH_DEF,
    parameter int DATA_W = cdeq_pkg::DATA_W_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  cdeq_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output cdeq_pkg::rsp_t  rsp
);
    import cdeq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam logic [PTR_W:0]   DEPTH_S = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_FILL = 3'b100
    } state_t;

    logic [DATA_W-1:0] mem [DEPTH];

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [CNT_W-1:0]  target_reg;
    logic [CNT_W-1:0]  target_next;
    logic [DATA_W-1:0] fill_reg;
    logic [DATA_W-1:0] fill_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              out_reg;
    rsp_t              out_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]  slot_k;
    logic [PTR_W:0]    slot_sum;
    logic [PTR_W:0]    slot_wrap;
    logic [PTR_W-1:0]  slot_addr;
    logic [PTR_W-1:0]  head_dec;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  count_p1;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  cnt_next_x;
    logic [63:0]       val_x;
    logic [DATA_W-1:0] cmd_val;
    logic [63:0]       rd_x;
    logic              is_full;
    logic              is_empty;
    logic              out_free;

    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;

    logic              res_emit;
    logic [DATA_W-1:0] res_rd;
    logic [STATUS_W-1:0] res_status;

    assign pos_x    = CMP_W'(cmd.position);
    assign cnt_x    = CMP_W'(count_reg);
    assign val_x    = 64'(cmd.value);
    assign cmd_val  = val_x[DATA_W-1:0];
    assign count_m1 = count_reg - 1'b1;
    assign count_p1 = count_reg + 1'b1;
    assign is_full  = count_reg == DEPTH_N;
    assign is_empty = count_reg == '0;
    assign out_free = !out_valid_reg || rsp_ready;
    assign head_dec = (head_reg == '0) ? LAST_P : head_reg - 1'b1;

    always_comb
    begin
        if (state_reg == S_FILL)
        begin
            slot_k = count_reg[PTR_W-1:0];
        end
        else
        begin
            unique case (cmd.kind)
                K_PUSH_BACK: slot_k = count_reg[PTR_W-1:0];
                K_POP_FRONT: slot_k = PTR_W'(1);
                K_BACK:      slot_k = count_m1[PTR_W-1:0];
                K_INDEX:     slot_k = pos_x[PTR_W-1:0];
                default:     slot_k = '0;
            endcase
        end
    end

    assign slot_sum  = {1'b0, head_reg} + {1'b0, slot_k};
    assign slot_wrap = slot_sum - DEPTH_S;
    assign slot_addr = (slot_sum >= DEPTH_S) ? slot_wrap[PTR_W-1:0] : slot_sum[PTR_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        target_next = target_reg;
        fill_next   = fill_reg;
        cmd_ready   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = slot_addr;
        mem_wdata   = cmd_val;
        mem_re      = 1'b0;
        res_emit    = 1'b0;
        res_rd      = '0;
        res_status  = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    res_emit  = 1'b1;
                    unique case (cmd.kind)
                        K_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_p1;
                            end
                        end
                        K_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_m1;
                            end
                        end
                        K_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                head_next  = head_dec;
                                count_next = count_p1;
                            end
                        end
                        K_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = slot_addr;
                                count_next = count_m1;
                            end
                        end
                        K_FRONT, K_BACK:
                        begin
                            if (is_empty)
                            begin
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                res_emit   = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        K_INDEX:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                res_status = ST_RANGE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                res_emit   = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        K_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                        end
                        K_RESIZE:
                        begin
                            if (pos_x > DEPTH_C)
                            begin
                                res_status = ST_FULL;
                            end
                            else if (pos_x > cnt_x)
                            begin
                                target_next = pos_x[CNT_W-1:0];
                                fill_next   = cmd_val;
                                res_emit    = 1'b0;
                                state_next  = S_FILL;
                            end
                            else
                            begin
                                count_next = pos_x[CNT_W-1:0];
                            end
                        end
                        default:
                        begin
                            res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_emit   = 1'b1;
                res_rd     = rd_data_reg;
                state_next = S_IDLE;
            end
            S_FILL:
            begin
                mem_we     = 1'b1;
                mem_wdata  = fill_reg;
                count_next = count_p1;
                if (count_p1 == target_reg)
                begin
                    res_emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cnt_next_x = CMP_W'(count_next);
    assign rd_x       = 64'(res_rd);

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        if (res_emit)
        begin
            out_valid_next         = 1'b1;
            out_next.read_value    = rd_x[VALUE_W-1:0];
            out_next.element_count = cnt_next_x[POS_W-1:0];
            out_next.status        = res_status;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        fill_reg   <= fill_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[slot_addr];
        end
    end

endmodule

>>> src/circular_double_ended_queue.sv
// Fixed-capacity double-ended queue of DEPTH elements of DATA_W bits held in a
// circular single-port-write, single-port-read memory, with one response transfer
// for every request transfer, in order. A decode stage and a two-entry command
// queue sit in front of the execution unit, so requests keep flowing while a
// response waits on rsp_ready. The execution unit finishes pushes, pops, size,
// clear, shrinking resizes and errors straight from its idle state, while front,
// back and index reads pass through a read state for the registered memory read.
// A growing resize writes one fill value per cycle in a fill state until the new
// size is reached. A request passes the decode register and the command queue
// before the execution unit, whose response is registered before rsp_valid rises.
// No memory initialization pass is needed after reset, since only elements
// inside the count are ever read.
module circular_double_ended_queue #(
    parameter int DEPTH  = cdeq_pkg::DEPTH_DEF,
    parameter int DATA_W = cdeq_pkg::DATA_W_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  cdeq_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output cdeq_pkg::rsp_t  rsp
);
    import cdeq_pkg::*;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;

    cdeq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    cdeq_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_cmd    (queue_cmd)
    );

    cdeq_back #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> src/cdeq_checker.sv
module cdeq_checker #(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input cdeq_pkg::req_t  req,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input cdeq_pkg::rsp_t  rsp
);
    import cdeq_pkg::*;

    // A request that has not been transferred stays put.
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed before its transfer");

    // A response that has not been transferred stays put.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed before its transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.element_count <= DEPTH)
        else $error("element count above capacity");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_EMPTY |-> rsp.read_value == '0
            && rsp.element_count == '0)
        else $error("empty status with data or nonzero count");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_RANGE)
            |-> rsp.read_value == '0)
        else $error("error status with nonzero read value");

endmodule

bind circular_double_ended_queue cdeq_checker #(
    .DEPTH (DEPTH)
) u_cdeq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
